### design/wsg_pkg.sv
package wsg_pkg;

  localparam int OP_W = 2;
  localparam int ADDR_W = 8;
  localparam int DATA_W = 8;
  localparam int SAMPLE_W = 15;

  localparam int CHANNELS = 5;
  localparam int WAVE_LEN = 32;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int RAM_BYTES = 256;
  localparam int WAVE_BYTES = CHANNELS * WAVE_LEN;
  localparam int REG_COUNT = 16;

  localparam logic [ADDR_W-1:0] NORMAL_REG_BASE = 8'h80;
  localparam logic [ADDR_W-1:0] PLUS_REG_BASE = 8'hA0;
  localparam int VOL_REG_BASE = 10;
  localparam int MIRROR_SRC = 3;
  localparam int MIRROR_DST = 4;

  localparam int CH_W = $clog2(CHANNELS);
  localparam int IDX_W = $clog2(WAVE_LEN);
  localparam int WAVE_AW = $clog2(WAVE_BYTES);
  localparam int RB_AW = $clog2(RAM_BYTES);
  localparam int REG_AW = $clog2(REG_COUNT);

  // phase is 13.frac, wrapping at 8192
  localparam int PHASE_INT_BITS = 13;
  localparam int PHASE_W = PHASE_INT_BITS + PHASE_FRAC_BITS;

  // increment = floor(INC_K / (period + 1))
  localparam longint unsigned CLOCK_X32 = 64'd111860 * 64'd32;
  localparam longint unsigned TICK_RATE = 64'd44100;
  localparam longint unsigned INC_K = (CLOCK_X32 << PHASE_FRAC_BITS) / TICK_RATE;
  localparam int PER_W = 12;
  localparam int DVS_W = PER_W + 1;
  localparam int QUO_W = $clog2(INC_K + 64'd1);
  localparam int DIV_STEPS = 4;
  localparam int DIV_ITER = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W = DIV_ITER * DIV_STEPS;
  localparam int DIV_CW = $clog2(DIV_ITER);

  localparam int VOL_W = 4;
  localparam int PROD_W = DATA_W + VOL_W + 1;
  localparam int SUM_W = 15;
  localparam int MIX_GAIN = 173;
  localparam int MIX_SHIFT = 7;
  localparam int MIX_BIAS = (1 << MIX_SHIFT) - 1;
  localparam int SCL_W = SUM_W + 8;
  localparam int SAMPLE_MAX = (128 * 15 * CHANNELS * MIX_GAIN) >> MIX_SHIFT;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MIRROR,
    S_RDWAIT,
    S_DIV,
    S_PHASE,
    S_ACC,
    S_SCALE,
    S_ROUND,
    S_DONE
  } st_t;

endpackage

### design/wsg_ram.sv
module wsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/wavetable_sound_generator.sv
// one item at a time: the next item is accepted only once the result is loaded
// a tick runs the shared 4-bit-per-cycle period divider once per channel
// synchronous active-low reset clears control, phases and sound registers, then a
// clearing pass zeroes both memories while in_ready is held low
module wavetable_sound_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wsg_pkg::OP_W-1:0]            in_opcode,
  input  logic [wsg_pkg::ADDR_W-1:0]          in_address,
  input  logic [wsg_pkg::DATA_W-1:0]          in_write_data,
  input  logic                                in_plus_layout,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wsg_pkg::DATA_W-1:0]          out_read_data,
  output logic signed [wsg_pkg::SAMPLE_W-1:0] out_sample_out
);
  import wsg_pkg::*;

  st_t st_r, st_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SCL_W-1:0] scaled_r, scaled_nxt;
  logic [DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic [SAMPLE_W-1:0] res_smp_r, res_smp_nxt;
  logic [IDX_W-1:0] mir_idx_r, mir_idx_nxt;
  logic [DATA_W-1:0] mir_data_r, mir_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic [SAMPLE_W-1:0] out_smp_r, out_smp_nxt;
  logic [RB_AW-1:0] clr_r, clr_nxt;

  logic [PHASE_W-1:0] phase_r [CHANNELS];
  logic [DATA_W-1:0] regs_r [REG_COUNT];

  logic in_acc;
  logic wave_we, wave_re;
  logic [WAVE_AW-1:0] wave_waddr, wave_raddr;
  logic [DATA_W-1:0] wave_wdata, wave_rdata;
  logic rb_we, rb_re;
  logic [RB_AW-1:0] rb_addr;
  logic [DATA_W-1:0] rb_wdata, rb_rdata;
  logic reg_we;
  logic [REG_AW-1:0] reg_widx;
  logic phase_we;
  logic [PHASE_W-1:0] phase_new;

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] step_rem;
  logic [DIV_W-1:0] step_quo;
  logic [DVS_W:0] trial;
  logic [VOL_W-1:0] vol;
  logic [DATA_W-1:0] smp;
  logic signed [PROD_W-1:0] prod;
  logic signed [SCL_W-1:0] adj;
  logic is_wave, is_reg, is_mirror;

  wsg_ram #(.WIDTH(DATA_W), .DEPTH(WAVE_BYTES)) u_wave_ram (
    .clk     (clk),
    .wr_en   (wave_we),
    .wr_addr (wave_waddr),
    .wr_data (wave_wdata),
    .rd_en   (wave_re),
    .rd_addr (wave_raddr),
    .rd_data (wave_rdata)
  );

  wsg_ram #(.WIDTH(DATA_W), .DEPTH(RAM_BYTES)) u_rb_ram (
    .clk     (clk),
    .wr_en   (rb_we),
    .wr_addr (rb_addr),
    .wr_data (rb_wdata),
    .rd_en   (rb_re),
    .rd_addr (rb_addr),
    .rd_data (rb_rdata)
  );

  assign in_ready       = (st_r == S_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_read_data  = out_rd_r;
  assign out_sample_out = out_smp_r;

  // address decode for both layouts
  always_comb begin
    if (in_plus_layout) begin
      is_wave = (in_address < PLUS_REG_BASE);
      is_reg  = (in_address >= PLUS_REG_BASE) &&
                (in_address < PLUS_REG_BASE + ADDR_W'(REG_COUNT));
      reg_widx = REG_AW'(in_address - PLUS_REG_BASE);
    end else begin
      is_wave = (in_address < NORMAL_REG_BASE);
      is_reg  = (in_address >= NORMAL_REG_BASE) &&
                (in_address < NORMAL_REG_BASE + ADDR_W'(REG_COUNT));
      reg_widx = REG_AW'(in_address - NORMAL_REG_BASE);
    end
    is_mirror = !in_plus_layout && is_wave &&
                (in_address[ADDR_W-1:IDX_W] == (ADDR_W-IDX_W)'(MIRROR_SRC));
  end

  // channel parameters from the sound registers
  assign dvs = DVS_W'({regs_r[{ch_r, 1'b1}][PER_W-DATA_W-1:0], regs_r[{ch_r, 1'b0}]}) +
               DVS_W'(1);
  assign vol = regs_r[REG_AW'(VOL_REG_BASE) + REG_AW'(ch_r)][VOL_W-1:0];

  // restoring divider, DIV_STEPS quotient bits per cycle
  always_comb begin
    step_rem = rem_r;
    step_quo = quo_r;
    trial    = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial    = {step_rem, step_quo[DIV_W-1]};
      step_quo = {step_quo[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        step_quo[0] = 1'b1;
      end
      step_rem = trial[DVS_W-1:0];
    end
  end

  assign phase_new = phase_r[ch_r] + PHASE_W'(quo_r);
  assign smp       = wave_rdata;
  assign prod      = $signed(smp) * $signed({1'b0, vol});
  assign adj       = scaled_r + (scaled_r[SCL_W-1] ? SCL_W'(MIX_BIAS) : SCL_W'(0));

  always_comb begin
    st_nxt        = st_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sum_nxt       = sum_r;
    scaled_nxt    = scaled_r;
    res_rd_nxt    = res_rd_r;
    res_smp_nxt   = res_smp_r;
    mir_idx_nxt   = mir_idx_r;
    mir_data_nxt  = mir_data_r;
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_smp_nxt   = out_smp_r;
    clr_nxt       = clr_r;
    wave_we       = 1'b0;
    wave_waddr    = WAVE_AW'(in_address);
    wave_wdata    = in_write_data;
    wave_re       = 1'b0;
    wave_raddr    = WAVE_AW'({ch_r, phase_new[PHASE_FRAC_BITS +: IDX_W]});
    rb_we         = 1'b0;
    rb_re         = 1'b0;
    rb_addr       = RB_AW'(in_address);
    rb_wdata      = in_write_data;
    reg_we        = 1'b0;
    phase_we      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_CLEAR: begin
        // zero both memories once after reset
        rb_we      = 1'b1;
        rb_addr    = clr_r;
        rb_wdata   = '0;
        wave_we    = (clr_r < RB_AW'(WAVE_BYTES));
        wave_waddr = WAVE_AW'(clr_r);
        wave_wdata = '0;
        clr_nxt    = clr_r + RB_AW'(1);
        if (clr_r == RB_AW'(RAM_BYTES - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_rd_nxt  = '0;
          res_smp_nxt = '0;
          st_nxt      = S_DONE;
          case (op_t'(in_opcode))
            OP_WRITE: begin
              rb_we        = 1'b1;
              wave_we      = is_wave;
              reg_we       = is_reg;
              mir_idx_nxt  = in_address[IDX_W-1:0];
              mir_data_nxt = in_write_data;
              if (is_mirror) begin
                st_nxt = S_MIRROR;
              end
            end
            OP_READ: begin
              rb_re  = 1'b1;
              st_nxt = S_RDWAIT;
            end
            OP_TICK: begin
              ch_nxt  = '0;
              sum_nxt = '0;
              cnt_nxt = '0;
              rem_nxt = '0;
              quo_nxt = DIV_W'(INC_K);
              st_nxt  = S_DIV;
            end
            default: begin
              st_nxt = S_DONE;
            end
          endcase
        end
      end
      S_MIRROR: begin
        // channel 3 wave is copied into channel 4
        wave_we    = 1'b1;
        wave_waddr = WAVE_AW'(MIRROR_DST * WAVE_LEN) + WAVE_AW'(mir_idx_r);
        wave_wdata = mir_data_r;
        st_nxt     = S_DONE;
      end
      S_RDWAIT: begin
        res_rd_nxt = rb_rdata;
        st_nxt     = S_DONE;
      end
      S_DIV: begin
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        cnt_nxt = cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_ITER - 1)) begin
          st_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        phase_we = 1'b1;
        wave_re  = 1'b1;
        st_nxt   = S_ACC;
      end
      S_ACC: begin
        sum_nxt = sum_r + SUM_W'(prod);
        if (ch_r == CH_W'(CHANNELS - 1)) begin
          st_nxt = S_SCALE;
        end else begin
          ch_nxt  = ch_r + CH_W'(1);
          cnt_nxt = '0;
          rem_nxt = '0;
          quo_nxt = DIV_W'(INC_K);
          st_nxt  = S_DIV;
        end
      end
      S_SCALE: begin
        scaled_nxt = SCL_W'(sum_r) * SCL_W'(MIX_GAIN);
        st_nxt     = S_ROUND;
      end
      S_ROUND: begin
        // divide by 128 truncating toward zero
        res_smp_nxt = adj[MIX_SHIFT +: SAMPLE_W];
        st_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_smp_nxt   = res_smp_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      cnt_r       <= '0;
      clr_r       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= '0;
      end
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      if (phase_we) begin
        phase_r[ch_r] <= phase_new;
      end
      if (reg_we) begin
        regs_r[reg_widx] <= in_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    sum_r      <= sum_nxt;
    scaled_r   <= scaled_nxt;
    res_rd_r   <= res_rd_nxt;
    res_smp_r  <= res_smp_nxt;
    mir_idx_r  <= mir_idx_nxt;
    mir_data_r <= mir_data_nxt;
    out_rd_r   <= out_rd_nxt;
    out_smp_r  <= out_smp_nxt;
  end

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && (!out_valid_r || out_ready)) |=> out_valid)
    else $error("finished result not loaded into output register");

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (rem_r < dvs))
    else $error("divider remainder not below divisor");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data == '0 || out_sample_out == '0))
    else $error("read data and sample both nonzero in one beat");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_out >= -SAMPLE_MAX && out_sample_out <= SAMPLE_MAX))
    else $error("mixed sample out of range");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import wsg_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;   // unused opcode, no effect
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int RAND_BEATS = 950;
  localparam int DIR_ROWS = 25;
  localparam int MAX_PRINTS = 40;
  // scc master clock times wave length, and the output sample rate
  localparam longint unsigned SCC_CLK_X32 = 64'd111860 * 64'd32;
  localparam longint unsigned SAMPLE_HZ = 64'd44100;
  localparam longint unsigned PHASE_WRAP = (64'd8192 << PHASE_FRAC_BITS) - 64'd1;

  typedef struct {
    logic [OP_W-1:0]            op;
    logic [ADDR_W-1:0]          addr;
    logic [DATA_W-1:0]          data;
    logic                       plus;
    logic                       typed;   // expectation given in the row itself
    logic [DATA_W-1:0]          rd;
    logic signed [SAMPLE_W-1:0] smp;
  } beat_t;

  typedef struct {
    logic [DATA_W-1:0]          rd;
    logic signed [SAMPLE_W-1:0] smp;
  } resp_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [OP_W-1:0]            in_opcode;
  logic [ADDR_W-1:0]          in_address;
  logic [DATA_W-1:0]          in_write_data;
  logic                       in_plus_layout;
  logic                       out_valid;
  logic                       out_ready;
  logic [DATA_W-1:0]          out_read_data;
  logic signed [SAMPLE_W-1:0] out_sample_out;

  wavetable_sound_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_plus_layout (in_plus_layout),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_sample_out (out_sample_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state
  logic [DATA_W-1:0] wave_mem [WAVE_BYTES];
  logic [DATA_W-1:0] shadow_bytes [RAM_BYTES];
  logic [DATA_W-1:0] snd_regs [REG_COUNT];
  logic [PHASE_W-1:0] phase_acc [CHANNELS];

  beat_t stim_q[$];
  resp_t pending_q[$];
  beat_t dir_tab [DIR_ROWS];
  bit calm = 1'b0;
  int err_cnt = 0;
  int acc_idx = 0;
  int n_cmp = 0;
  int n_wr = 0, n_rd = 0, n_tick = 0, n_none = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                          input logic [DATA_W-1:0] d, input logic pl);
    beat_t b;
    b = '{op, a, d, pl, 1'b0, 8'h00, 15'sd0};
    stim_q.push_back(b);
  endtask

  // mixed sample of one tick: advance every channel, sum sample * volume, scale by 173/128
  task automatic run_tick(output logic signed [SAMPLE_W-1:0] smp);
    longint unsigned per, step, ph;
    int idx, s, vol, acc;
    acc = 0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      per = {snd_regs[2*ch+1][3:0], snd_regs[2*ch]};
      step = (SCC_CLK_X32 << PHASE_FRAC_BITS) / (SAMPLE_HZ * (per + 64'd1));
      ph = (longint'(phase_acc[ch]) + step) & PHASE_WRAP;
      phase_acc[ch] = ph[PHASE_W-1:0];
      idx = int'((ph >> PHASE_FRAC_BITS) % WAVE_LEN);
      s = $signed(wave_mem[ch*WAVE_LEN + idx]);
      vol = int'(snd_regs[VOL_REG_BASE + ch][3:0]);
      acc += s * vol;
    end
    acc = acc * 173;
    smp = SAMPLE_W'(acc / 128);   // truncates toward zero
  endtask

  task automatic apply_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] d, input logic pl,
                            output resp_t r);
    int ai;
    ai = int'(a);
    r.rd = '0;
    r.smp = '0;
    if (op == OP_WRITE) begin
      shadow_bytes[a] = d;
      if (!pl) begin
        if (ai < int'(NORMAL_REG_BASE)) begin
          wave_mem[ai] = d;
          if (ai / WAVE_LEN == MIRROR_SRC) wave_mem[MIRROR_DST*WAVE_LEN + ai % WAVE_LEN] = d;
        end else if (ai < int'(NORMAL_REG_BASE) + REG_COUNT) begin
          snd_regs[ai - int'(NORMAL_REG_BASE)] = d;
        end
      end else begin
        if (ai < int'(PLUS_REG_BASE)) wave_mem[ai] = d;
        else if (ai < int'(PLUS_REG_BASE) + REG_COUNT) snd_regs[ai - int'(PLUS_REG_BASE)] = d;
      end
    end else if (op == OP_READ) begin
      r.rd = shadow_bytes[a];
    end else if (op == OP_TICK) begin
      run_tick(r.smp);
    end
  endtask

  // voice setup bursts with random content, mixed with loose noise beats
  task automatic build_traffic();
    int ch, n0;
    logic lay;
    logic [ADDR_W-1:0] base;
    n0 = stim_q.size();
    while (stim_q.size() - n0 < RAND_BEATS) begin
      if ($urandom_range(0, 9) < 6) begin
        ch = $urandom_range(0, CHANNELS - 1);
        // wave 4 is only written directly in the plus layout
        lay = (ch == MIRROR_DST) ? 1'b1 : 1'($urandom_range(0, 1));
        base = lay ? PLUS_REG_BASE : NORMAL_REG_BASE;
        repeat ($urandom_range(1, 6))
          add_beat(OP_WRITE, 8'(ch*WAVE_LEN + $urandom_range(0, WAVE_LEN - 1)),
                   pick_byte(), lay);
        if ($urandom_range(0, 1) == 1) begin
          add_beat(OP_WRITE, 8'(base + 2*ch), pick_byte(), lay);
          add_beat(OP_WRITE, 8'(base + 2*ch + 1), pick_byte(), lay);
        end
        if ($urandom_range(0, 2) == 0)
          add_beat(OP_WRITE, 8'(base + VOL_REG_BASE + ch), pick_byte(), lay);
        repeat ($urandom_range(1, 6))
          add_beat(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 1) == 1)
          add_beat(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        add_beat(2'($urandom_range(0, 3)), 8'($urandom), pick_byte(), 1'($urandom));
      end
    end
  endtask

  // result side: compare against the oldest pending expectation
  // input side: run the predictor on every accepted beat
  always @(posedge clk) begin : scoreboard
    resp_t want, pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: rd=%0d smp=%0d",
                                    out_read_data, out_sample_out));
        end else begin
          want = pending_q.pop_front();
          n_cmp++;
          if (out_read_data !== want.rd)
            report_mismatch($sformatf("result %0d read_data: expected %0d got %0d",
                                      n_cmp, want.rd, out_read_data));
          if (out_sample_out !== want.smp)
            report_mismatch($sformatf("result %0d sample_out: expected %0d got %0d",
                                      n_cmp, want.smp, out_sample_out));
        end
      end
      if (in_valid && in_ready) begin
        apply_beat(in_opcode, in_address, in_write_data, in_plus_layout, pred);
        if (stim_q[acc_idx].typed) begin
          want.rd = stim_q[acc_idx].rd;
          want.smp = stim_q[acc_idx].smp;
          pending_q.push_back(want);
        end else begin
          pending_q.push_back(pred);
        end
        acc_idx++;
        case (in_opcode)
          OP_WRITE: n_wr++;
          OP_READ:  n_rd++;
          OP_TICK:  n_tick++;
          default:  n_none++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : sink
    int stall;
    out_ready <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int gap;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_WRITE;
    in_address     <= '0;
    in_write_data  <= '0;
    in_plus_layout <= 1'b0;
    foreach (wave_mem[i]) wave_mem[i] = '0;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
    foreach (snd_regs[i]) snd_regs[i] = '0;
    foreach (phase_acc[i]) phase_acc[i] = '0;

    // op, addr, data, plus, typed, read_data, sample_out
    dir_tab = '{
      '{OP_READ,  8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 15'sd0},  // empty after reset
      '{OP_READ,  8'hFF, 8'h00, 1'b1, 1'b1, 8'h00, 15'sd0},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 15'sd0},  // silent: all volumes zero
      '{OP_WRITE, 8'h00, 8'hFF, 1'b0, 1'b1, 8'h00, 15'sd0},
      '{OP_WRITE, 8'h7F, 8'h80, 1'b0, 1'b1, 8'h00, 15'sd0},  // wave 3, mirrored
      '{OP_READ,  8'h7F, 8'h00, 1'b0, 1'b1, 8'h80, 15'sd0},
      '{OP_WRITE, 8'hFF, 8'hA5, 1'b1, 1'b1, 8'h00, 15'sd0},  // read-back only
      '{OP_READ,  8'hFF, 8'h00, 1'b0, 1'b1, 8'hA5, 15'sd0},
      '{OP_WRITE, 8'h8A, 8'h0F, 1'b0, 1'b1, 8'h00, 15'sd0},  // ch0 volume max
      '{OP_WRITE, 8'h8E, 8'h0F, 1'b0, 1'b1, 8'h00, 15'sd0},  // ch4 volume max
      '{OP_WRITE, 8'h80, 8'h00, 1'b0, 1'b1, 8'h00, 15'sd0},
      '{OP_TICK,  8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 15'sd0},
      '{OP_WRITE, 8'h9F, 8'h7F, 1'b1, 1'b1, 8'h00, 15'sd0},  // wave 4 via plus layout
      '{OP_WRITE, 8'hA0, 8'hFF, 1'b1, 1'b1, 8'h00, 15'sd0},
      '{OP_WRITE, 8'hA1, 8'hFF, 1'b1, 1'b1, 8'h00, 15'sd0},  // ch0 period 4095
      '{OP_WRITE, 8'hAF, 8'h5A, 1'b1, 1'b1, 8'h00, 15'sd0},  // last plus register
      '{OP_WRITE, 8'hB0, 8'h11, 1'b1, 1'b1, 8'h00, 15'sd0},  // just past plus registers
      '{OP_WRITE, 8'h90, 8'h22, 1'b0, 1'b1, 8'h00, 15'sd0},  // just past normal registers
      '{OP_READ,  8'h90, 8'h00, 1'b0, 1'b1, 8'h22, 15'sd0},
      '{OP_READ,  8'hAF, 8'h00, 1'b1, 1'b1, 8'h5A, 15'sd0},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 15'sd0},
      '{OP_TICK,  8'h55, 8'hAA, 1'b1, 1'b0, 8'h00, 15'sd0},
      '{OP_NONE,  8'hFF, 8'hFF, 1'b1, 1'b1, 8'h00, 15'sd0},  // unused opcode
      '{OP_WRITE, 8'h60, 8'h7F, 1'b0, 1'b1, 8'h00, 15'sd0},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 15'sd0}
    };
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    build_traffic();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < stim_q.size(); k++) begin
      // every so often switch to a stretch with no idling on either side
      if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_opcode      <= stim_q[k].op;
      in_address     <= stim_q[k].addr;
      in_write_data  <= stim_q[k].data;
      in_plus_layout <= stim_q[k].plus;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

    $display("run covered %0d writes, %0d reads, %0d ticks, %0d unused-opcode beats",
             n_wr, n_rd, n_tick, n_none);
    $display("%0d results compared, %0d mismatches", n_cmp, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
